[rtl/wwkc_pkg.sv]
// Package for the whole-word keyword counter: sizes, item type, register
// codes and the byte classification helpers. No dependencies.
`default_nettype none

package wwkc_pkg;

	localparam int KEY_MAX       = 32;
	localparam int COUNT_BITS    = 32;
	localparam int KEY_SRC_BYTES = 32;
	localparam int KEY_IDX_W     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int KEY_LEN_W     = 6;
	localparam int CH_W          = 8;
	localparam int OUT_W         = 32;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int QUEUE_PTR_W   = 2;
	localparam int QUEUE_DEPTH   = 1 << QUEUE_PTR_W;
	localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_WORD0 = 3'd0,
		REG_KEY_WORD1 = 3'd1,
		REG_KEY_WORD2 = 3'd2,
		REG_KEY_WORD3 = 3'd3,
		REG_KEY_LEN   = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_SPACE = 2'd1,
		KIND_EOT   = 2'd2
	} item_kind_t;

	typedef logic [KEY_MAX-1:0][CH_W-1:0] key_bytes_t;

	typedef struct packed {
		item_kind_t      kind;
		logic [CH_W-1:0] ch;      // folded
		logic            letter;
	} item_t;

	function automatic logic [CH_W-1:0] fold_byte(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]})
			r = c + 8'd32;
		return r;
	endfunction

	function automatic logic is_letter(input logic [CH_W-1:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic logic is_space(input logic [CH_W-1:0] c);
		return (c inside {8'h20, [8'h09:8'h0D]});
	endfunction

endpackage

`default_nettype wire

[rtl/wwkc_front.sv]
// Front end: classifies incoming bytes (fold, letter, whitespace, end of
// text) and queues them for the back end. Uses wwkc_pkg.
`default_nettype none

module wwkc_front
	import wwkc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [CH_W-1:0] ch,
	input  wire logic            end_of_text,
	output logic                 item_valid,
	input  wire logic            item_ready,
	output item_t                item
);

	item_t                  q_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	item_t                  cls;
	logic                   push, pop;

	always_comb begin
		cls.ch     = fold_byte(ch);
		cls.letter = is_letter(ch);
		if (end_of_text)
			cls.kind = KIND_EOT;
		else if (is_space(ch))
			cls.kind = KIND_SPACE;
		else
			cls.kind = KIND_CHAR;
	end

	assign in_ready   = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = q_q[rd_ptr_q];
	assign push       = in_valid & in_ready;
	assign pop        = item_valid & item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_ptr_q] <= cls;
	end

endmodule

`default_nettype wire

[rtl/wwkc_back.sv]
// Back end: shift-and prefix matcher over the keyword, whole-word judging,
// saturating count and the result register. Uses wwkc_pkg.
`default_nettype none

module wwkc_back
	import wwkc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire item_t                item,
	input  wire key_bytes_t           key_bytes,
	input  wire logic [KEY_IDX_W-1:0] key_sel,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OUT_W-1:0]          match_total
);

	// m_q[j]: the last j+1 token bytes equal keyword bytes 0..j
	// lb_q[j]: the byte before that partial match was a letter
	logic [KEY_MAX-1:0]    m_q, lb_q, m_next, lb_next;
	logic                  prev_letter_q, awaiting_q, decided_q;
	logic [COUNT_BITS-1:0] count_q, count_inc;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      match_total_q;
	logic                  pop, hit, lb_hit;

	assign item_ready  = !(item.kind == KIND_EOT && out_valid_q && !out_ready);
	assign pop         = item_valid & item_ready;
	assign out_valid   = out_valid_q;
	assign match_total = match_total_q;
	assign count_inc   = (count_q != '1) ? count_q + 1'b1 : count_q;

	always_comb begin
		for (int j = 0; j < KEY_MAX; j++) begin
			if (j == 0) begin
				m_next[j]  = (item.ch == key_bytes[j]);
				lb_next[j] = prev_letter_q;
			end else begin
				m_next[j]  = m_q[j-1] & (item.ch == key_bytes[j]);
				lb_next[j] = lb_q[j-1];
			end
		end
		hit    = m_next[key_sel];
		lb_hit = lb_next[key_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q           <= '0;
			prev_letter_q <= 1'b0;
			awaiting_q    <= 1'b0;
			decided_q     <= 1'b0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop && item.kind == KIND_EOT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (pop) begin
				case (item.kind)
					KIND_CHAR: begin
						m_q           <= m_next;
						prev_letter_q <= item.letter;
						if (awaiting_q) begin
							awaiting_q <= 1'b0;
							if (!item.letter)
								count_q <= count_inc;
						end else if (!decided_q && hit) begin
							decided_q  <= 1'b1;
							awaiting_q <= !lb_hit;
						end
					end
					KIND_SPACE: begin
						if (awaiting_q)
							count_q <= count_inc;
						m_q           <= '0;
						prev_letter_q <= 1'b0;
						awaiting_q    <= 1'b0;
						decided_q     <= 1'b0;
					end
					KIND_EOT: begin
						count_q       <= '0;
						m_q           <= '0;
						prev_letter_q <= 1'b0;
						awaiting_q    <= 1'b0;
						decided_q     <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.kind == KIND_CHAR)
			lb_q <= lb_next;
		if (pop && item.kind == KIND_EOT)
			match_total_q <= OUT_W'(awaiting_q ? count_inc : count_q);
	end

endmodule

`default_nettype wire

[rtl/whole_word_keyword_counter.sv]
// Whole-word keyword counter, top level: keyword registers, front and back.
// Result path: an end-of-text beat is written into the queue, then the back end registers the result and out_valid.
// Throughput: one byte per cycle; a 4-entry queue absorbs output stalls, which
// hold the back end only on an end-of-text beat while a result waits.
// Reset clears queue, match state and count; keyword is zeros, length one.
// Depends on wwkc_pkg, wwkc_front, wwkc_back.
`default_nettype none

module whole_word_keyword_counter
	import wwkc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [CH_W-1:0]        ch,
	input  wire logic                   end_of_text,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_W-1:0]            match_total,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	key_bytes_t           key_q;
	logic [KEY_IDX_W-1:0] key_sel_q;   // effective length minus one
	logic [KEY_LEN_W-1:0] len_in;
	logic                 item_valid, item_ready;
	item_t                item;

	assign len_in = cfg_wdata[KEY_LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_sel_q <= '0;
		end else if (cfg_we) begin
			for (int k = 0; k < KEY_MAX; k++) begin
				if (k < KEY_SRC_BYTES && cfg_index == CFG_INDEX_W'(k >> 3))
					key_q[k] <= fold_byte(cfg_wdata[8*(k & 7) +: CH_W]);
			end
			if (cfg_index == REG_KEY_LEN) begin
				if (len_in == '0)
					key_sel_q <= '0;
				else if (int'(len_in) > KEY_MAX)
					key_sel_q <= KEY_IDX_W'(KEY_MAX - 1);
				else
					key_sel_q <= KEY_IDX_W'(len_in - 1'b1);
			end
		end
	end

	wwkc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.end_of_text(end_of_text),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	wwkc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.key_bytes  (key_q),
		.key_sel    (key_sel_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.match_total(match_total)
	);

endmodule

`default_nettype wire

[rtl/wwkc_checker.sv]
// Port-level checks for the whole-word keyword counter, bound to the top.
// Uses wwkc_pkg.
`default_nettype none

module wwkc_checker
	import wwkc_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [OUT_W-1:0] match_total
);

	// result beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_total))
		else $error("result changed or dropped while stalled");

	// result only goes away when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	// no result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

endmodule

bind whole_word_keyword_counter wwkc_checker u_wwkc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.match_total(match_total)
);

`default_nettype wire
